/* rtl/i2c_master_byte_engine_assert.svh */
// Assertion helpers shared by the engine RTL.
// Both forms are clocked on i_clk and muted while i_rst_n is low.
`ifndef I2C_MASTER_BYTE_ENGINE_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_ASSERT_SVH

// Same-cycle implication.
`define I2CMBE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define I2CMBE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/i2cmbe_pkg.sv */
`default_nettype none

package i2cmbe_pkg;

    localparam int CMD_W    = 3;
    localparam int BYTE_W   = 8;
    localparam int STAT_W   = 2;
    localparam int TICKS_W  = 8;
    localparam int PHASE_W  = 5;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 16;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // command / operation codes
    localparam logic [CMD_W-1:0] OP_IDLE   = 3'd0;
    localparam logic [CMD_W-1:0] OP_START  = 3'd1;
    localparam logic [CMD_W-1:0] OP_STOP   = 3'd2;
    localparam logic [CMD_W-1:0] OP_SEND   = 3'd3;
    localparam logic [CMD_W-1:0] OP_RXACK  = 3'd4;
    localparam logic [CMD_W-1:0] OP_RXNACK = 3'd5;

    // completion status
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_NACK = 2'd1;
    localparam logic [STAT_W-1:0] ST_BUSY = 2'd2;
    localparam logic [STAT_W-1:0] ST_ERR  = 2'd3;

    // register map
    localparam logic [APB_AW-1:0] REG_PHASE_TICKS = 3'd0;
    localparam logic [TICKS_W-1:0] PHASE_TICKS_RST = 8'd2;

    // one input beat: tick with optional command
    typedef struct packed {
        logic              sda_in;
        logic [BYTE_W-1:0] tx_byte;
        logic [CMD_W-1:0]  cmd;
    } t_item;

    // one output beat
    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic [STAT_W-1:0] status;
        logic              done_res;
        logic              busy_res;
        logic              sda_out;
        logic              scl_out;
    } t_result;

endpackage

`default_nettype wire

/* rtl/i2cmbe_in_stage.sv */
`default_nettype none

module i2cmbe_in_stage (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire i2cmbe_pkg::t_item  i_item,
    input  wire logic               i_take,
    output logic                    o_ready,
    output logic                    o_valid,
    output i2cmbe_pkg::t_item       o_item
);
    import i2cmbe_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/i2cmbe_core.sv */
`default_nettype none

`include "i2c_master_byte_engine_assert.svh"

module i2cmbe_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_advance,
    input  wire i2cmbe_pkg::t_item              i_item,
    input  wire logic [i2cmbe_pkg::TICKS_W-1:0] i_phase_ticks,
    output i2cmbe_pkg::t_result                 o_res
);
    import i2cmbe_pkg::*;

    // phase numbers of interest
    localparam logic [PHASE_W-1:0] PH_START_SAMPLE = 5'd1;
    localparam logic [PHASE_W-1:0] PH_START_LAST   = 5'd3;
    localparam logic [PHASE_W-1:0] PH_STOP_LAST    = 5'd2;
    localparam logic [PHASE_W-1:0] PH_SEND_REL     = 5'd24;
    localparam logic [PHASE_W-1:0] PH_SEND_LAST    = 5'd25;
    localparam logic [PHASE_W-1:0] PH_RX_ACKDRV    = 5'd16;
    localparam logic [PHASE_W-1:0] PH_RX_ACKCLK    = 5'd17;
    localparam logic [PHASE_W-1:0] PH_RX_LAST      = 5'd18;

    typedef struct packed {
        logic              scl;
        logic              sda;
        logic [BYTE_W-1:0] shift;
    } t_drv;

    typedef struct packed {
        logic              done;
        logic [STAT_W-1:0] code;
        t_drv              drv;
        logic [BYTE_W-1:0] rx;
    } t_end;

    // position within a three-phase send bit slot
    function automatic logic [1:0] slot3(input logic [PHASE_W-1:0] idx);
        logic [1:0] r;
        case (idx) inside
            5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18, 5'd21:  r = 2'd0;
            5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16, 5'd19, 5'd22: r = 2'd1;
            default:                                             r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic t_drv enter_phase(input logic [CMD_W-1:0] op,
                                         input logic [PHASE_W-1:0] idx,
                                         input t_drv d);
        t_drv q;
        q = d;
        case (op)
            OP_START: begin
                case (idx)
                    5'd0:    q.sda = 1'b1;
                    5'd1:    q.scl = 1'b1;
                    5'd2:    q.sda = 1'b0;
                    default: q.scl = 1'b0;
                endcase
            end
            OP_STOP: begin
                case (idx)
                    5'd0:    q.sda = 1'b0;
                    5'd1:    q.scl = 1'b1;
                    default: q.sda = 1'b1;
                endcase
            end
            OP_SEND: begin
                if (idx < PH_SEND_REL) begin
                    case (slot3(idx))
                        2'd0: begin
                            q.scl   = 1'b0;
                            q.sda   = d.shift[BYTE_W-1];
                            q.shift = {d.shift[BYTE_W-2:0], 1'b0};
                        end
                        2'd1:    q.scl = 1'b1;
                        default: q.scl = 1'b0;
                    endcase
                end else if (idx == PH_SEND_REL) begin
                    q.sda = 1'b1;
                end else begin
                    q.scl = 1'b1;
                end
            end
            default: begin
                if (idx < PH_RX_ACKDRV) begin
                    if (!idx[0]) begin
                        q.scl = 1'b1;
                        if (idx == '0) q.sda = 1'b1;
                    end else begin
                        q.scl = 1'b0;
                    end
                end else if (idx == PH_RX_ACKDRV) begin
                    q.sda = (op == OP_RXNACK);
                end else if (idx == PH_RX_ACKCLK) begin
                    q.scl = 1'b1;
                end else begin
                    q.scl = 1'b0;
                end
            end
        endcase
        return q;
    endfunction

    function automatic t_end end_phase(input logic [CMD_W-1:0] op,
                                       input logic [PHASE_W-1:0] idx,
                                       input logic sda,
                                       input t_drv d,
                                       input logic [BYTE_W-1:0] rx);
        t_end e;
        e.done = 1'b0;
        e.code = ST_OK;
        e.drv  = d;
        e.rx   = rx;
        case (op)
            OP_START: begin
                if (idx == PH_START_SAMPLE && !sda) begin
                    e.done = 1'b1;
                    e.code = ST_BUSY;
                end else if (idx == PH_START_LAST) begin
                    e.done = 1'b1;
                    e.code = sda ? ST_ERR : ST_OK;
                end
            end
            OP_STOP: begin
                e.done = (idx == PH_STOP_LAST);
            end
            OP_SEND: begin
                if (idx == PH_SEND_LAST) begin
                    e.done    = 1'b1;
                    e.code    = sda ? ST_NACK : ST_OK;
                    e.drv.scl = 1'b0;
                end
            end
            default: begin
                if (idx < PH_RX_ACKDRV && !idx[0]) begin
                    e.drv.shift = {d.shift[BYTE_W-2:0], sda};
                end
                if (idx == PH_RX_LAST) begin
                    e.done = 1'b1;
                    e.rx   = e.drv.shift;
                end
            end
        endcase
        return e;
    endfunction

    logic [CMD_W-1:0]   r_op,    n_op;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [TICKS_W-1:0] r_tick,  n_tick;
    t_drv               r_drv,   n_drv;
    logic [BYTE_W-1:0]  r_rx,    n_rx;

    logic               start_now;
    logic [CMD_W-1:0]   op_a;
    logic [PHASE_W-1:0] phase_a;
    logic [TICKS_W-1:0] tick_a;
    t_drv               drv_a;
    t_drv               drv_seed;
    logic [TICKS_W-1:0] len;
    logic               last;
    t_end               ep;
    logic               done;

    always_comb begin
        start_now = (r_op == OP_IDLE) && (i_item.cmd inside {[OP_START:OP_RXNACK]});
        op_a      = start_now ? i_item.cmd : r_op;
        phase_a   = start_now ? '0 : r_phase;
        tick_a    = start_now ? '0 : r_tick;
        drv_seed  = r_drv;
        if (start_now) begin
            drv_seed.shift = (i_item.cmd == OP_SEND) ? i_item.tx_byte : '0;
        end
        drv_a = start_now ? enter_phase(op_a, '0, drv_seed) : r_drv;

        len  = (i_phase_ticks == '0) ? TICKS_W'(1) : i_phase_ticks;
        last = ({1'b0, tick_a} + (TICKS_W+1)'(1)) >= {1'b0, len};
        ep   = end_phase(op_a, phase_a, i_item.sda_in, drv_a, r_rx);

        n_op    = op_a;
        n_phase = phase_a;
        n_tick  = tick_a;
        n_drv   = drv_a;
        n_rx    = r_rx;
        done    = 1'b0;
        if (op_a != OP_IDLE) begin
            if (last) begin
                n_rx   = ep.rx;
                n_tick = '0;
                if (ep.done) begin
                    done    = 1'b1;
                    n_op    = OP_IDLE;
                    n_phase = '0;
                    n_drv   = ep.drv;
                end else begin
                    n_phase = phase_a + PHASE_W'(1);
                    n_drv   = enter_phase(op_a, n_phase, ep.drv);
                end
            end else begin
                n_tick = tick_a + TICKS_W'(1);
            end
        end

        o_res.scl_out  = n_drv.scl;
        o_res.sda_out  = n_drv.sda;
        o_res.busy_res = (n_op != OP_IDLE);
        o_res.done_res = done;
        o_res.status   = done ? ep.code : ST_OK;
        o_res.rx_byte  = n_rx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op      <= OP_IDLE;
            r_phase   <= '0;
            r_tick    <= '0;
            r_drv.scl <= 1'b1;
            r_drv.sda <= 1'b1;
            r_drv.shift <= '0;
            r_rx      <= '0;
        end else if (i_advance) begin
            r_op    <= n_op;
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_drv   <= n_drv;
            r_rx    <= n_rx;
        end
    end

    `I2CMBE_ASSERT_IMP(a_done_not_busy, i_advance && o_res.done_res, !o_res.busy_res,
        "done beat also flagged busy")
    `I2CMBE_ASSERT_IMP(a_status_only_on_done, i_advance && !o_res.done_res,
        o_res.status == ST_OK, "status nonzero outside done")
    `I2CMBE_ASSERT_IMP(a_phase_range, 1'b1, r_phase <= PH_SEND_LAST,
        "phase index beyond longest sequence")
    `I2CMBE_ASSERT_IMP(a_idle_clean, r_op == OP_IDLE, r_phase == '0 && r_tick == '0,
        "idle engine holds stale phase or tick")
    `I2CMBE_ASSERT_NXT(a_hold_on_stall, !i_advance,
        $stable(r_op) && $stable(r_tick) && $stable(r_phase), "state moved without a beat")

endmodule

`default_nettype wire

/* rtl/i2cmbe_out_stage.sv */
`default_nettype none

module i2cmbe_out_stage (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_load,
    input  wire i2cmbe_pkg::t_result  i_res,
    input  wire logic                 i_ready,
    output logic                      o_can_load,
    output logic                      o_valid,
    output i2cmbe_pkg::t_result       o_res
);
    import i2cmbe_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

/* rtl/i2c_master_byte_engine.sv */
// Bit-level I2C master timing engine. Each input beat is one bus tick: it carries the
// sampled SDA level and, when the engine is idle, a command (start, stop, send byte,
// receive byte with ACK or NACK; other codes and commands given while busy are ignored).
// Each input beat yields exactly one output beat with the SCL/SDA drive levels after that
// tick, busy, a one-tick done flag with its status (ok/ack, nack, bus busy, bus error)
// and the last received byte. Every bus phase is held for phase_ticks ticks (register at
// APB address 0, reset 2, zero acts as one); write it only while no command is running.
// Throughput is one beat per clock while neither side stalls: a beat goes through an input
// register, one pass of the sequencer logic and an output register, and either side may
// stall freely without loss. No clearing pass after reset.
`default_nettype none

module i2c_master_byte_engine (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // input beat: [2:0] cmd, [10:3] tx_byte, [11] sda_in, [15:12] zero
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [i2cmbe_pkg::S_DATA_W-1:0] s_axis_tdata,
    // output beat: [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res,
    // [5:4] status, [13:6] rx_byte, [15:14] zero
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [i2cmbe_pkg::M_DATA_W-1:0]      m_axis_tdata,
    // register port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [i2cmbe_pkg::APB_AW-1:0]   paddr,
    input  wire logic [i2cmbe_pkg::APB_DW-1:0]   pwdata,
    output logic [i2cmbe_pkg::APB_DW-1:0]        prdata,
    output logic                                 pready
);
    import i2cmbe_pkg::*;

    logic [TICKS_W-1:0] r_phase_ticks;

    t_item   s_item;
    t_item   q_item;
    logic    q_valid;
    logic    out_can_load;
    logic    advance;
    t_result core_res;
    t_result m_res;

    // ---- register port: always ready, single register ----
    assign pready = 1'b1;
    assign prdata = (paddr == REG_PHASE_TICKS) ?
                    {{(APB_DW-TICKS_W){1'b0}}, r_phase_ticks} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RST;
        end else if (psel && penable && pwrite && pready && paddr == REG_PHASE_TICKS) begin
            r_phase_ticks <= pwdata[TICKS_W-1:0];
        end
    end

    // ---- beat unpack ----
    assign s_item = s_axis_tdata[$bits(t_item)-1:0];

    // a queued tick advances whenever the output register can take its result
    assign advance = q_valid && out_can_load;

    i2cmbe_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_item  (s_item),
        .i_take  (advance),
        .o_ready (s_axis_tready),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    i2cmbe_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (advance),
        .i_item        (q_item),
        .i_phase_ticks (r_phase_ticks),
        .o_res         (core_res)
    );

    i2cmbe_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .i_res      (core_res),
        .i_ready    (m_axis_tready),
        .o_can_load (out_can_load),
        .o_valid    (m_axis_tvalid),
        .o_res      (m_res)
    );

    assign m_axis_tdata = {{(M_DATA_W-$bits(t_result)){1'b0}}, m_res};

endmodule

`default_nettype wire
